@@ hw/rtl/murmur_style_hash_64_assert.svh @@
// Assertion macros shared by the murmur_style_hash_64 RTL.
// Self-contained; included by modules that carry concurrent checks.
`ifndef MURMUR_STYLE_HASH_64_ASSERT_SVH
`define MURMUR_STYLE_HASH_64_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MH64_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhash64: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MH64_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhash64: next-cycle check failed");

`endif

@@ hw/rtl/mhash64_pkg.sv @@
// Package for murmur_style_hash_64: mixing constants, queue sizing, shared types.
// No dependencies.
`timescale 1ns / 1ps

package mhash64_pkg;

    // Block and hash mixing constants
    localparam logic [63:0] MIX_C1      = 64'hFC34_0BE1_DD38_1CBB;
    localparam logic [63:0] MIX_C2      = 64'hC375_A1BB_3CDA_1011;
    localparam logic [63:0] HASH_ADD    = 64'h0007_8BA4_EC69_BAAE;
    localparam logic [63:0] FIN_C1      = 64'hC32B_A869_A6CE_7BDE;
    localparam logic [63:0] FIN_C2      = 64'h3ECB_791D_B936_21FF;
    localparam logic [63:0] BLOCK_BYTES = 64'd8;

    localparam int unsigned BLOCK_ROT = 15;
    localparam int unsigned HASH_ROT  = 13;
    // Times five is (h << 2) + h
    localparam int unsigned HASH_MUL_SHIFT = 2;
    localparam int unsigned FIN_SHIFT = 16;
    localparam int unsigned FIN_MID   = 13;

    // Block queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [63:0] word;
        logic        is_first;
        logic        is_last;
    } blk_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_ROUND,
        ST_PREFIN,
        ST_FIN1,
        ST_FIN2,
        ST_EMIT
    } state_t;

    // Pass of the shared 32x32 multiplier: low*low, low*high, high*low
    typedef enum logic [1:0] {
        PH_LL,
        PH_LH,
        PH_HL
    } mul_phase_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (32'd64 - r));
    endfunction

endpackage

@@ hw/rtl/mhash64_queue.sv @@
// Short block queue between the front and back of murmur_style_hash_64.
// Depends on mhash64_pkg.
`timescale 1ns / 1ps

module mhash64_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  mhash64_pkg::blk_entry_t wr_data,
    output logic                    full,
    input  logic                    rd_en,
    output mhash64_pkg::blk_entry_t rd_data,
    output logic                    empty
);
    import mhash64_pkg::*;

    blk_entry_t           slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/mhash64_front.sv @@
// Front of murmur_style_hash_64: accepts block beats and tags message starts.
// Depends on mhash64_pkg.
`timescale 1ns / 1ps

module mhash64_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [63:0]             block_word,
    input  logic                    last_block,
    output logic                    q_wr_en,
    output mhash64_pkg::blk_entry_t q_wr_data,
    input  logic                    q_full
);
    import mhash64_pkg::*;

    logic in_message_reg;
    logic in_message_next;
    logic accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Tag the first block of each message so the back end reloads the seed
    assign q_wr_en   = accept;
    assign q_wr_data = '{word: block_word, is_first: !in_message_reg, is_last: last_block};

    always_comb
    begin
        in_message_next = in_message_reg;
        if (accept)
        begin
            in_message_next = !last_block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
        end
        else
        begin
            in_message_reg <= in_message_next;
        end
    end

endmodule

@@ hw/rtl/mhash64_back.sv @@
// Back of murmur_style_hash_64: block mixing, hash round, finalizer, result slot.
// Depends on mhash64_pkg and murmur_style_hash_64_assert.svh.
`timescale 1ns / 1ps
`include "murmur_style_hash_64_assert.svh"

module mhash64_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [63:0]             seed_val,
    input  logic                    q_empty,
    input  mhash64_pkg::blk_entry_t q_rd_data,
    output logic                    q_rd_en,
    output logic                    empty,
    input  logic                    pop,
    output logic [63:0]             hash_value
);
    import mhash64_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    mul_phase_t  phase_reg;
    mul_phase_t  phase_next;

    logic [63:0] op_a_reg;
    logic [63:0] acc_reg;
    logic [63:0] run_hash_reg;
    logic [63:0] len_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [63:0] hash_out_reg;

    logic        is_mul;
    logic        mul_done;
    logic        out_free;
    logic        load_out;
    logic [63:0] mul_b;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] prod;
    logic [63:0] acc_next;
    logic [63:0] mixed;
    logic [63:0] round_hash;
    logic [63:0] fin_pre;

    assign empty      = !out_valid_reg;
    assign hash_value = hash_out_reg;
    assign out_free   = !out_valid_reg || pop;

    assign is_mul   = (state_reg == ST_MIX1) || (state_reg == ST_MIX2) ||
                      (state_reg == ST_FIN1) || (state_reg == ST_FIN2);
    assign mul_done = is_mul && (phase_reg == PH_HL);

    // Shared 32x32 multiplier; three passes give the low 64 bits of a 64x64 product
    assign mul_x    = (phase_reg == PH_HL) ? op_a_reg[63:32] : op_a_reg[31:0];
    assign mul_y    = (phase_reg == PH_LH) ? mul_b[63:32] : mul_b[31:0];
    assign prod     = mul_x * mul_y;
    assign acc_next = (phase_reg == PH_LL) ? prod :
                      {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};

    assign mixed      = rotl64(run_hash_reg ^ acc_reg, HASH_ROT);
    assign round_hash = (mixed << HASH_MUL_SHIFT) + mixed + HASH_ADD;
    assign fin_pre    = (run_hash_reg ^ len_reg) ^ ((run_hash_reg ^ len_reg) >> FIN_SHIFT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = ST_MIX1;
            ST_MIX1:   if (mul_done) state_next = ST_MIX2;
            ST_MIX2:   if (mul_done) state_next = ST_ROUND;
            ST_ROUND:  state_next = last_reg ? ST_PREFIN : ST_IDLE;
            ST_PREFIN: state_next = ST_FIN1;
            ST_FIN1:   if (mul_done) state_next = ST_FIN2;
            ST_FIN2:   if (mul_done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase

        phase_next = PH_LL;
        if (is_mul)
        begin
            unique case (phase_reg)
                PH_LL:   phase_next = PH_LH;
                PH_LH:   phase_next = PH_HL;
                PH_HL:   phase_next = PH_LL;
                default: phase_next = PH_LL;
            endcase
        end
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_rd_en  = (state_reg == ST_IDLE) && !q_empty;
        load_out = (state_reg == ST_EMIT) && out_free;
        unique case (state_reg)
            ST_MIX1: mul_b = MIX_C1;
            ST_MIX2: mul_b = MIX_C2;
            ST_FIN1: mul_b = FIN_C1;
            ST_FIN2: mul_b = FIN_C2;
            default: mul_b = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_LL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath; the running hash and length always reload at a message start
    always_ff @(posedge clk)
    begin
        if (is_mul)
        begin
            acc_reg <= acc_next;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_rd_en)
                begin
                    op_a_reg <= q_rd_data.word;
                    last_reg <= q_rd_data.is_last;
                    if (q_rd_data.is_first)
                    begin
                        run_hash_reg <= seed_val;
                        len_reg      <= '0;
                    end
                end
            end
            ST_MIX1:
            begin
                if (mul_done)
                begin
                    op_a_reg <= rotl64(acc_next, BLOCK_ROT);
                end
            end
            ST_ROUND:
            begin
                run_hash_reg <= round_hash;
                len_reg      <= len_reg + BLOCK_BYTES;
            end
            ST_PREFIN:
            begin
                op_a_reg <= fin_pre;
            end
            ST_FIN1:
            begin
                if (mul_done)
                begin
                    op_a_reg <= acc_next ^ (acc_next >> FIN_MID);
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    hash_out_reg <= acc_reg ^ (acc_reg >> FIN_SHIFT);
                end
            end
            default:
            begin
            end
        endcase
    end

    `MH64_ASSERT_IMP(a_phase_only_in_mul, clk, rst_n, (phase_reg != PH_LL), (is_mul))
    `MH64_ASSERT_NXT(a_emit_fills_slot, clk, rst_n, (load_out), (out_valid_reg && state_reg == ST_IDLE))
    `MH64_ASSERT_NXT(a_mid_block_returns, clk, rst_n, (state_reg == ST_ROUND && !last_reg), (state_reg == ST_IDLE))
    `MH64_ASSERT_IMP(a_result_from_emit, clk, rst_n, $rose(out_valid_reg), ($past(state_reg) == ST_EMIT))

endmodule

@@ hw/rtl/murmur_style_hash_64.sv @@
// Top level of murmur_style_hash_64: seed register, front, block queue, back.
// Depends on mhash64_pkg, mhash64_front, mhash64_queue and mhash64_back.
`timescale 1ns / 1ps

// murmur_style_hash_64 hashes a message delivered as 64-bit little-endian block
// beats (final block zero padded, marked by last_block) and returns one 64-bit
// hash per message. Both sides look like a queue: push a block beat while full
// is low; take the hash while empty is low by raising pop. The front accepts
// beats into a two-entry queue and tags message starts; the back works one
// block at a time on a single shared 32x32 multiplier, three passes per 64-bit
// constant multiply. Each block goes through a dequeue, two multiplies and one
// hash round in the back; the last block then adds a length fold, two finalizer
// multiplies and a result load. A finished hash waits in a one-beat result slot
// while the next message keeps flowing. The user must write the seed through
// seed_we and seed only while the block is idle; the block does not enforce it.
// The seed is loaded at each message start.

module murmur_style_hash_64 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] block_word,
    input  logic        last_block,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] hash_value,
    input  logic        seed_we,
    input  logic [63:0] seed
);
    import mhash64_pkg::*;

    logic [63:0] seed_reg;
    logic [63:0] seed_next;

    logic        q_wr_en;
    blk_entry_t  q_wr_data;
    logic        q_full;
    logic        q_rd_en;
    blk_entry_t  q_rd_data;
    logic        q_empty;

    // Hold the seed until the next write
    always_comb
    begin
        seed_next = seed_we ? seed : seed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    // Accept and tag block beats
    mhash64_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .block_word (block_word),
        .last_block (last_block),
        .q_wr_en    (q_wr_en),
        .q_wr_data  (q_wr_data),
        .q_full     (q_full)
    );

    // Decouple intake from the multiply sequence
    mhash64_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Mix, round, finalize and present the hash
    mhash64_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_val   (seed_reg),
        .q_empty    (q_empty),
        .q_rd_data  (q_rd_data),
        .q_rd_en    (q_rd_en),
        .empty      (empty),
        .pop        (pop),
        .hash_value (hash_value)
    );

endmodule
